### sv/bsr_pkg.sv
// Package of the bridge converter serial reader: sizes, codes, record types
// and small helper functions. Depends on nothing; every other file imports it.
`default_nettype none

package bsr_pkg;

  // Converter word and averaging limits.
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned MAX_AVERAGE = 64;
  localparam int unsigned BIT_CNT_W   = $clog2(SAMPLE_BITS + 1);

  // Fixed field widths of the ports.
  localparam int unsigned AVG_W    = 7;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned VALUE_W  = 24;
  localparam int unsigned NET_W    = 25;
  localparam int unsigned SCALE_W  = 32;
  localparam int unsigned UNITS_W  = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W   = NET_W + SCALE_W;
  localparam int unsigned SHIFT_W  = PROD_W - FRAC_BITS;
  localparam int unsigned REM_W    = AVG_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W);
  localparam int unsigned CFG_DATA_W = 32;

  // Queue between the front and back ends.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_TARE   = 2'd1,
    REQ_OFFSET = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_GAIN  = 2'd0,
    CFG_AVG   = 2'd1,
    CFG_SCALE = 2'd2,
    CFG_PDOWN = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GAIN_128     = 2'd0,
    GAIN_64      = 2'd1,
    GAIN_32      = 2'd2,
    GAIN_128_ALT = 2'd3
  } gain_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_GAIN = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_DIV  = 3'd1,
    BK_SIGN = 3'd2,
    BK_NET  = 3'd3,
    BK_MUL  = 3'd4,
    BK_OUT  = 3'd5
  } back_state_e;

  typedef struct packed {
    gain_e                     gain;
    logic [AVG_W-1:0]          avg_count;
    logic signed [SCALE_W-1:0] recip_scale;
    logic                      standby;
  } cfg_t;

  // One classified item as handed from the front end to the back end.
  typedef struct packed {
    logic               sck;
    logic               seen;
    logic               avg_done;
    logic               tare;
    logic               load_offset;
    logic [VALUE_W-1:0] offset;
    logic [SUM_W-1:0]   sum;
    logic [AVG_W-1:0]   count;
  } rec_t;

  // Number of trailing clock pulses that select the next gain.
  function automatic logic [1:0] extra_pulses(gain_e g);
    logic [1:0] n;
    unique case (g)
      GAIN_64:      n = 2'd3;
      GAIN_32:      n = 2'd2;
      GAIN_128,
      GAIN_128_ALT: n = 2'd1;
      default:      n = 2'd1;
    endcase
    return n;
  endfunction

  // Averaging count limited to the range 1 to MAX_AVERAGE.
  function automatic logic [AVG_W-1:0] clamp_avg(logic [AVG_W-1:0] a);
    logic [AVG_W-1:0] r;
    priority if (a == '0) begin
      r = AVG_W'(1);
    end else if (a > AVG_W'(MAX_AVERAGE)) begin
      r = AVG_W'(MAX_AVERAGE);
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/bridge_adc_serial_reader.sv
// Top level of the bridge converter serial reader: configuration registers,
// front end, item queue and back end. Depends on bsr_pkg, bsr_front,
// bsr_fifo and bsr_back.
`default_nettype none

// The reader is advanced one converter clock tick per input transfer. A tick
// request steps the two-wire sequence: wait in idle for the data line to go
// low, give a clock pulse per data bit (a high tick, then a low tick on which
// the data bit is taken, most significant bit first), then one to three extra
// pulses that choose the next gain. Completed samples are summed; once the set
// count is reached the sum is divided, truncating toward zero, into the
// average, the stored offset is subtracted into the net value, and the net
// value is multiplied by the Q16.16 reciprocal scale, floored and saturated
// into the units value. Every input transfer gives exactly one result
// transfer. A tare request stores the next average as the offset, and an
// offset request loads the offset directly without a tick. Setting the
// standby register drives the clock line high and drops any read in progress.
// Rate: the front end takes one transfer per cycle while the four-entry
// queue has room. The back end takes one item at a time: the 32-step serial
// divider and sign state for an item completing an average, then the net,
// product and output states; the result then waits in the output register
// while the queue keeps taking transfers. The user must write configuration
// only while the reader has no result outstanding; this is not enforced.
module bridge_adc_serial_reader (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port.
  input  wire logic                                 cfg_we_i,
  input  wire logic [1:0]                           cfg_idx_i,
  input  wire logic [bsr_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // Input queue side.
  input  wire logic                                 push_i,
  output logic                                      full_o,
  input  wire logic [1:0]                           req_type_i,
  input  wire logic                                 dout_level_i,
  input  wire logic signed [bsr_pkg::VALUE_W-1:0]   new_offset_i,
  // Result queue side.
  output logic                                      empty_o,
  input  wire logic                                 pop_i,
  output logic                                      sck_level_o,
  output logic                                      conversion_seen_o,
  output logic                                      average_valid_o,
  output logic signed [bsr_pkg::VALUE_W-1:0]        average_value_o,
  output logic signed [bsr_pkg::NET_W-1:0]          net_value_o,
  output logic signed [bsr_pkg::UNITS_W-1:0]        units_value_o
);
  import bsr_pkg::*;

  cfg_t cfg_q;
  rec_t front_rec;
  rec_t fifo_rec;
  logic accept;
  logic fifo_empty;
  logic fifo_rd;

  assign accept = push_i && !full_o;

  // Configuration registers; an index beyond the list changes nothing as all
  // four codes are in use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain        <= GAIN_128;
      cfg_q.avg_count   <= AVG_W'(1);
      cfg_q.recip_scale <= SCALE_W'(65536);
      cfg_q.standby     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN:  cfg_q.gain        <= gain_e'(cfg_wdata_i[1:0]);
        CFG_AVG:   cfg_q.avg_count   <= cfg_wdata_i[AVG_W-1:0];
        CFG_SCALE: cfg_q.recip_scale <= cfg_wdata_i[SCALE_W-1:0];
        CFG_PDOWN: cfg_q.standby     <= cfg_wdata_i[0];
        default:   cfg_q.standby     <= cfg_q.standby;
      endcase
    end
  end

  bsr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .dout_level_i (dout_level_i),
    .new_offset_i (new_offset_i),
    .cfg_i        (cfg_q),
    .rec_o        (front_rec)
  );

  bsr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (front_rec),
    .rd_i    (fifo_rd),
    .rdata_o (fifo_rec),
    .full_o  (full_o),
    .empty_o (fifo_empty)
  );

  bsr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_i             (fifo_rec),
    .fifo_empty_i      (fifo_empty),
    .fifo_rd_o         (fifo_rd),
    .recip_scale_i     (cfg_q.recip_scale),
    .pop_i             (pop_i),
    .empty_o           (empty_o),
    .sck_level_o       (sck_level_o),
    .conversion_seen_o (conversion_seen_o),
    .average_valid_o   (average_valid_o),
    .average_value_o   (average_value_o),
    .net_value_o       (net_value_o),
    .units_value_o     (units_value_o)
  );

  // A conversion is found only in idle, and an average completes only at the
  // end of the gain pulses, so one result never carries both.
  a_seen_not_avg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && conversion_seen_o |-> !average_valid_o)
    else $error("conversion seen and average completed in one result");

  // Finding a conversion starts the read with the clock line low.
  a_seen_clock_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && conversion_seen_o |-> !sck_level_o)
    else $error("clock high on the tick that found a conversion");

  // An average completes on the low half of the last gain pulse.
  a_avg_clock_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && average_valid_o |-> !sck_level_o)
    else $error("clock high on the tick that completed an average");

endmodule

`default_nettype wire

### sv/bsr_fifo.sv
// Short queue of classified items between the front and back ends.
// Depends on bsr_pkg for the record type and the depth.
`default_nettype none

module bsr_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  bsr_pkg::rec_t      wdata_i,
  input  wire logic          rd_i,
  output bsr_pkg::rec_t      rdata_o,
  output logic               full_o,
  output logic               empty_o
);
  import bsr_pkg::*;

  rec_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o  = (cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### sv/bsr_front.sv
// Front end: takes each request, runs the two-wire read sequence and the
// sample accumulation, and emits one classified record. Depends on bsr_pkg.
`default_nettype none

module bsr_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic                         dout_level_i,
  input  wire logic [bsr_pkg::VALUE_W-1:0]  new_offset_i,
  input  bsr_pkg::cfg_t                     cfg_i,
  output bsr_pkg::rec_t                     rec_o
);
  import bsr_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic                   clk_high_q, clk_high_d;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  logic [1:0]             pulse_q, pulse_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [AVG_W-1:0]       scnt_q, scnt_d;
  logic                   tare_q, tare_d;

  req_e                   req;
  logic                   tick;
  logic                   bit_last;
  logic                   pulse_last;
  logic [SUM_W-1:0]       sum_inc;
  logic [AVG_W-1:0]       cnt_inc;

  assign req        = req_e'(req_type_i);
  assign tick       = accept_i && ((req == REQ_TICK) || (req == REQ_TARE));
  assign bit_last   = (bit_cnt_q == BIT_CNT_W'(SAMPLE_BITS - 1));
  assign pulse_last = (({1'b0, pulse_q} + 3'd1) >= {1'b0, extra_pulses(cfg_i.gain)});
  assign sum_inc    = sum_q + {{(SUM_W - SAMPLE_BITS){shift_q[SAMPLE_BITS-1]}}, shift_q};
  assign cnt_inc    = scnt_q + 1'b1;

  // Read sequence phase.
  always_comb begin
    phase_d = phase_q;
    if (tick) begin
      if (cfg_i.standby) begin
        phase_d = PH_IDLE;
      end else begin
        unique case (phase_q)
          PH_IDLE: if (!dout_level_i) phase_d = PH_DATA;
          PH_DATA: if (clk_high_q && bit_last) phase_d = PH_GAIN;
          PH_GAIN: if (clk_high_q && pulse_last) phase_d = PH_IDLE;
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Shift, counters, accumulation and the record handed on.
  always_comb begin
    bit_cnt_d  = bit_cnt_q;
    clk_high_d = clk_high_q;
    shift_d    = shift_q;
    pulse_d    = pulse_q;
    sum_d      = sum_q;
    scnt_d     = scnt_q;
    tare_d     = tare_q;

    rec_o             = '0;
    rec_o.load_offset = accept_i && (req == REQ_OFFSET);
    rec_o.offset      = new_offset_i;
    rec_o.sum         = sum_inc;
    rec_o.count       = cnt_inc;

    if (accept_i && (req == REQ_TARE)) begin
      tare_d = 1'b1;
    end

    if (tick) begin
      if (cfg_i.standby) begin
        bit_cnt_d  = '0;
        clk_high_d = 1'b0;
        shift_d    = '0;
        pulse_d    = '0;
      end else if (phase_q == PH_IDLE) begin
        if (!dout_level_i) begin
          rec_o.seen = 1'b1;
          bit_cnt_d  = '0;
          clk_high_d = 1'b0;
          shift_d    = '0;
        end
      end else if (!clk_high_q) begin
        clk_high_d = 1'b1;
      end else if (phase_q == PH_DATA) begin
        clk_high_d = 1'b0;
        shift_d    = {shift_q[SAMPLE_BITS-2:0], dout_level_i};
        bit_cnt_d  = bit_cnt_q + 1'b1;
        if (bit_last) begin
          pulse_d = '0;
        end
      end else begin
        clk_high_d = 1'b0;
        pulse_d    = pulse_q + 1'b1;
        if (pulse_last) begin
          bit_cnt_d = '0;
          shift_d   = '0;
          pulse_d   = '0;
          if (cnt_inc >= clamp_avg(cfg_i.avg_count)) begin
            rec_o.avg_done = 1'b1;
            rec_o.tare     = tare_d;
            tare_d         = 1'b0;
            sum_d          = '0;
            scnt_d         = '0;
          end else begin
            sum_d  = sum_inc;
            scnt_d = cnt_inc;
          end
        end
      end
    end

    rec_o.sck = cfg_i.standby ? 1'b1 : clk_high_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= '0;
      clk_high_q <= 1'b0;
      shift_q    <= '0;
      pulse_q    <= '0;
      sum_q      <= '0;
      scnt_q     <= '0;
      tare_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      clk_high_q <= clk_high_d;
      shift_q    <= shift_d;
      pulse_q    <= pulse_d;
      sum_q      <= sum_d;
      scnt_q     <= scnt_d;
      tare_q     <= tare_d;
    end
  end

endmodule

`default_nettype wire

### sv/bsr_back.sv
// Back end: serial divide of the sample sum, offset subtraction, scale
// multiply with saturation, and the result register. Depends on bsr_pkg.
`default_nettype none

module bsr_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  bsr_pkg::rec_t                            rec_i,
  input  wire logic                                fifo_empty_i,
  output logic                                     fifo_rd_o,
  input  wire logic signed [bsr_pkg::SCALE_W-1:0]  recip_scale_i,
  input  wire logic                                pop_i,
  output logic                                     empty_o,
  output logic                                     sck_level_o,
  output logic                                     conversion_seen_o,
  output logic                                     average_valid_o,
  output logic signed [bsr_pkg::VALUE_W-1:0]       average_value_o,
  output logic signed [bsr_pkg::NET_W-1:0]         net_value_o,
  output logic signed [bsr_pkg::UNITS_W-1:0]       units_value_o
);
  import bsr_pkg::*;

  back_state_e             st_q, st_d;
  rec_t                    rec_q;
  logic                    neg_q;
  logic [SUM_W-1:0]        mag_q;
  logic [REM_W-1:0]        rem_q;
  logic [DIV_CNT_W-1:0]    div_cnt_q;
  logic [VALUE_W-1:0]      last_avg_q;
  logic [VALUE_W-1:0]      offset_q;
  logic signed [NET_W-1:0] net_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    out_valid_q;

  logic                    out_free;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W:0]          trial;
  logic [REM_W-1:0]        rem_next;
  logic                    qbit;
  logic [SUM_W-1:0]        quot;
  logic [NET_W-1:0]        net_d;
  logic signed [PROD_W-1:0] net_ext, scale_ext;
  logic [SHIFT_W-1:0]      shifted;
  logic [UNITS_W-1:0]      units_d;

  assign out_free  = !out_valid_q || pop_i;
  assign empty_o   = !out_valid_q;

  // Sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (!fifo_empty_i) st_d = rec_i.avg_done ? BK_DIV : BK_NET;
      BK_DIV:  if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) st_d = BK_SIGN;
      BK_SIGN: st_d = BK_NET;
      BK_NET:  st_d = BK_MUL;
      BK_MUL:  st_d = BK_OUT;
      BK_OUT:  if (out_free) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    fifo_rd_o = (st_q == BK_IDLE) && !fifo_empty_i;
  end

  // One restoring divide step per cycle, then sign, net, product and clamp.
  always_comb begin
    rem_sh   = {rem_q[REM_W-2:0], mag_q[SUM_W-1]};
    trial    = {1'b0, rem_sh} - {2'b00, rec_q.count};
    qbit     = !trial[REM_W];
    rem_next = qbit ? trial[REM_W-1:0] : rem_sh;
    quot     = neg_q ? (~mag_q + 1'b1) : mag_q;

    net_d     = {last_avg_q[VALUE_W-1], last_avg_q} - {offset_q[VALUE_W-1], offset_q};
    net_ext   = {{(PROD_W - NET_W){net_q[NET_W-1]}}, net_q};
    scale_ext = {{(PROD_W - SCALE_W){recip_scale_i[SCALE_W-1]}}, recip_scale_i};

    // The arithmetic shift floors; saturate when the upper bits disagree.
    shifted = prod_q[PROD_W-1:FRAC_BITS];
    if (shifted[SHIFT_W-1:UNITS_W-1] == '0 || shifted[SHIFT_W-1:UNITS_W-1] == '1) begin
      units_d = shifted[UNITS_W-1:0];
    end else if (shifted[SHIFT_W-1]) begin
      units_d = {1'b1, {(UNITS_W - 1){1'b0}}};
    end else begin
      units_d = {1'b0, {(UNITS_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      out_valid_q <= 1'b0;
      last_avg_q  <= '0;
      offset_q    <= '0;
    end else begin
      st_q <= st_d;
      if (fifo_rd_o && rec_i.load_offset) begin
        offset_q <= rec_i.offset;
      end
      if (st_q == BK_SIGN) begin
        last_avg_q <= quot[VALUE_W-1:0];
        if (rec_q.tare) begin
          offset_q <= quot[VALUE_W-1:0];
        end
      end
      if (st_q == BK_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_rd_o) begin
      rec_q     <= rec_i;
      neg_q     <= rec_i.sum[SUM_W-1];
      mag_q     <= rec_i.sum[SUM_W-1] ? (~rec_i.sum + 1'b1) : rec_i.sum;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end
    if (st_q == BK_DIV) begin
      mag_q     <= {mag_q[SUM_W-2:0], qbit};
      rem_q     <= rem_next;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (st_q == BK_NET) begin
      net_q <= net_d;
    end
    if (st_q == BK_MUL) begin
      prod_q <= net_ext * scale_ext;
    end
    if (st_q == BK_OUT && out_free) begin
      sck_level_o       <= rec_q.sck;
      conversion_seen_o <= rec_q.seen;
      average_valid_o   <= rec_q.avg_done;
      average_value_o   <= last_avg_q;
      net_value_o       <= net_q;
      units_value_o     <= units_d;
    end
  end

endmodule

`default_nettype wire
